>>> design/cfd_pkg.sv
package cfd_pkg;

  // One link or payload byte
  typedef logic [7:0] byte_t;

  // Frame delimiter on the link
  localparam byte_t DELIM = 8'h00;

  // Block count at which a code byte marks a full block (code 0xFF)
  localparam byte_t CODE_FULL_COUNT = 8'hFE;

  // Byte inserted between blocks
  localparam byte_t FILL_ZERO = 8'h00;

  // One decoded result item
  typedef struct packed {
    byte_t data_byte;
    logic  frame_last;
    logic  frame_empty;
    logic  frame_bad;
  } result_t;

endpackage

>>> design/cfd_link_if.sv
interface cfd_link_if;
  import cfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t link_byte;

  modport source (output valid, output link_byte, input ready);
  modport sink (input valid, input link_byte, output ready);
endinterface

>>> design/cfd_result_if.sv
interface cfd_result_if;
  import cfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_last;
  logic  frame_empty;
  logic  frame_bad;

  modport source (
    output valid, output data_byte, output frame_last, output frame_empty,
    output frame_bad, input ready
  );
  modport sink (
    input valid, input data_byte, input frame_last, input frame_empty,
    input frame_bad, output ready
  );
endinterface

>>> design/cobs_frame_decoder_core.sv
// Streaming decoder for zero-delimited COBS frames.
// link (sink): one raw link byte per item; 0x00 delimits frames. Bytes seen
//   before the first delimiter are dropped; a delimiter opens a frame and
//   the next delimiter closes it.
// result (source): decoded payload bytes, one per item. frame_last marks the
//   final item of a frame, frame_empty marks the single item of an empty
//   frame (data_byte 0), frame_bad marks a final item whose frame closed
//   inside a block.
// One decoded byte is held back, so a payload byte leaves when the next
//   decoded byte or the closing delimiter arrives.
// Throughput: one link item per cycle while the result register is free or
//   being taken. The decode step is a small counter update between the link
//   handshake and the result register, so a result shows in the cycle after the link item that causes it.
// Stall: the result register holds its item while result.ready is low, and
//   link.ready stays low only while a held result is not taken.
// Reset (rst, synchronous): clears the frame state and the result valid;
//   the block starts hunting for a frame delimiter.
module cobs_frame_decoder_core (
  input  logic         clk,
  input  logic         rst,
  cfd_link_if.sink     link,
  cfd_result_if.source result
);
  import cfd_pkg::*;

  logic    inside_frame, inside_frame_next;
  logic    want_code, want_code_next;
  byte_t   bytes_left, bytes_left_next;
  logic    full_block, full_block_next;
  logic    zero_due, zero_due_next;
  logic    hold_valid, hold_valid_next;
  byte_t   hold_byte, hold_byte_next;

  logic    out_valid;
  result_t out_item;
  logic    res_fire;
  result_t res_item;
  logic    accept;
  byte_t   b;
  byte_t   count;
  byte_t   left_dec;

  // Take a link item whenever the result register is free or being taken
  assign link.ready = !out_valid || result.ready;
  assign accept     = link.valid && link.ready;
  assign b          = link.link_byte;
  assign count      = b - 8'd1;
  assign left_dec   = bytes_left - 8'd1;

  // Decode one link item
  always_comb begin
    inside_frame_next = inside_frame;
    want_code_next    = want_code;
    bytes_left_next   = bytes_left;
    full_block_next   = full_block;
    zero_due_next     = zero_due;
    hold_valid_next   = hold_valid;
    hold_byte_next    = hold_byte;
    res_fire          = 1'b0;
    res_item          = '{data_byte: hold_byte, frame_last: 1'b0,
                          frame_empty: 1'b0, frame_bad: 1'b0};

    if (!inside_frame) begin
      // Hunt for a delimiter to open a frame
      if (b == DELIM) begin
        inside_frame_next = 1'b1;
        want_code_next    = 1'b1;
        bytes_left_next   = '0;
        full_block_next   = 1'b0;
        zero_due_next     = 1'b0;
        hold_valid_next   = 1'b0;
      end
    end else if (b == DELIM) begin
      // Close the frame: pass the held byte or an empty-frame item
      res_fire             = 1'b1;
      res_item.frame_last  = 1'b1;
      res_item.frame_bad   = !want_code;
      if (!hold_valid) begin
        res_item.data_byte   = '0;
        res_item.frame_empty = 1'b1;
      end
      inside_frame_next = 1'b0;
      want_code_next    = 1'b1;
      bytes_left_next   = '0;
      full_block_next   = 1'b0;
      zero_due_next     = 1'b0;
      hold_valid_next   = 1'b0;
    end else if (want_code) begin
      // Code byte: push the owed zero, then start the block
      if (zero_due) begin
        res_fire        = hold_valid;
        hold_byte_next  = FILL_ZERO;
        hold_valid_next = 1'b1;
      end
      full_block_next = (count >= CODE_FULL_COUNT);
      bytes_left_next = count;
      if (count == 8'd0) begin
        want_code_next = 1'b1;
        zero_due_next  = 1'b1;
      end else begin
        want_code_next = 1'b0;
        zero_due_next  = 1'b0;
      end
    end else begin
      // Data byte: advance through the hold
      res_fire        = hold_valid;
      hold_byte_next  = b;
      hold_valid_next = 1'b1;
      bytes_left_next = left_dec;
      if (left_dec == 8'd0) begin
        want_code_next = 1'b1;
        zero_due_next  = !full_block;
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      want_code    <= 1'b1;
      bytes_left   <= '0;
      full_block   <= 1'b0;
      zero_due     <= 1'b0;
      hold_valid   <= 1'b0;
    end else if (accept) begin
      inside_frame <= inside_frame_next;
      want_code    <= want_code_next;
      bytes_left   <= bytes_left_next;
      full_block   <= full_block_next;
      zero_due     <= zero_due_next;
      hold_valid   <= hold_valid_next;
    end
  end

  // Held byte
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= hold_byte_next;
    end
  end

  // Result register: load on a producing item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_fire;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      out_item <= res_item;
    end
  end

  assign result.valid       = out_valid;
  assign result.data_byte   = out_item.data_byte;
  assign result.frame_last  = out_item.frame_last;
  assign result.frame_empty = out_item.frame_empty;
  assign result.frame_bad   = out_item.frame_bad;

endmodule

>>> design/cfd_checker.sv
module cfd_checker (
  input logic          clk,
  input logic          rst,
  input logic          link_valid,
  input logic          link_ready,
  input logic          res_valid,
  input logic          res_ready,
  input cfd_pkg::byte_t data_byte,
  input logic          frame_last,
  input logic          frame_empty,
  input logic          frame_bad
);
  import cfd_pkg::*;

  // A stalled result item holds
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(data_byte) &&
      $stable(frame_last) && $stable(frame_empty) && $stable(frame_bad))
    else $error("stalled result item changed");

  // No link item is taken while a result waits
  a_link_blocked: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !link_ready)
    else $error("link taken while result stalled");

  // A new result item only follows a taken link item
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(link_valid && link_ready))
    else $error("result item without a link item");

  // Empty-frame items are final and carry a zero byte
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_empty |-> frame_last && (data_byte == '0))
    else $error("malformed empty-frame item");

  // A bad mark only rides on the final item
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_bad |-> frame_last)
    else $error("bad mark on non-final item");

endmodule

bind cobs_frame_decoder_core cfd_checker u_cfd_checker (
  .clk         (clk),
  .rst         (rst),
  .link_valid  (link.valid),
  .link_ready  (link.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .data_byte   (result.data_byte),
  .frame_last  (result.frame_last),
  .frame_empty (result.frame_empty),
  .frame_bad   (result.frame_bad)
);

>>> sim/tb.sv
module tb;
  import cfd_pkg::*;

  // Directed rows: typed result, no result, or checked against the decoder model
  typedef enum {ROW_QUIET, ROW_MODEL, ROW_TYPED} row_kind_t;

  typedef struct {
    byte_t     b;
    row_kind_t kind;
    result_t   want;
  } row_t;

  localparam int PHASE_ITEMS = 200;

  logic clk;
  logic rst;

  cfd_link_if   link ();
  cfd_result_if result ();

  cobs_frame_decoder_core DUT (
    .clk    (clk),
    .rst    (rst),
    .link   (link),
    .result (result)
  );

  // Decoder model state
  bit    p_in_frame;
  bit    p_want_code;
  byte_t p_bytes_left;
  bit    p_full_block;
  bit    p_zero_due;
  bit    p_hold_valid;
  byte_t p_hold_byte;

  result_t decoded_due[$];
  byte_t   link_plan[$];
  int      mismatches;
  int      send_idle;
  int      recv_idle;
  result_t got;
  result_t want;

  int send_pct[3] = '{35, 79, 0};
  int recv_pct[3] = '{79, 35, 0};

  row_t dir_rows[25] = '{
    '{8'h55, ROW_QUIET, '0},                          // bytes before a start
    '{8'hFF, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0},                          // open
    '{8'h00, ROW_TYPED, '{8'h00, 1'b1, 1'b1, 1'b0}},  // empty frame
    '{8'h00, ROW_QUIET, '0},                          // back-to-back delimiter opens
    '{8'h01, ROW_QUIET, '0},                          // empty block, zero due
    '{8'h03, ROW_QUIET, '0},
    '{8'hFF, ROW_MODEL, '0},
    '{8'h80, ROW_MODEL, '0},
    '{8'h00, ROW_TYPED, '{8'h80, 1'b1, 1'b0, 1'b0}},  // pending zero dropped
    '{8'h00, ROW_QUIET, '0},
    '{8'h04, ROW_MODEL, '0},
    '{8'h01, ROW_MODEL, '0},
    '{8'h7F, ROW_MODEL, '0},
    '{8'h00, ROW_TYPED, '{8'h7F, 1'b1, 1'b0, 1'b1}},  // ends inside a block
    '{8'h00, ROW_QUIET, '0},
    '{8'h05, ROW_MODEL, '0},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b1, 1'b1, 1'b1}},  // bad with nothing held
    '{8'h00, ROW_QUIET, '0},
    '{8'hFF, ROW_MODEL, '0},                          // full block code
    '{8'hAA, ROW_MODEL, '0},
    '{8'h00, ROW_TYPED, '{8'hAA, 1'b1, 1'b0, 1'b1}},
    '{8'h00, ROW_QUIET, '0},
    '{8'h01, ROW_MODEL, '0},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b1, 1'b1, 1'b0}}
  };

  // Clear the decoder model; in_frame selects hunting or a fresh frame
  function automatic void clear_decoder(input bit in_frame);
    p_in_frame   = in_frame;
    p_want_code  = 1'b1;
    p_bytes_left = '0;
    p_full_block = 1'b0;
    p_zero_due   = 1'b0;
    p_hold_valid = 1'b0;
    p_hold_byte  = '0;
  endfunction

  // Pass a decoded byte through the one-byte hold
  function automatic bit pass_through_hold(input byte_t b, output result_t r);
    bit hit;
    hit = p_hold_valid;
    r   = '{p_hold_byte, 1'b0, 1'b0, 1'b0};
    p_hold_byte  = b;
    p_hold_valid = 1'b1;
    return hit;
  endfunction

  // Advance the decoder model by one link byte; return 1 when a result leaves
  function automatic bit cobs_predict(input byte_t b, output result_t r);
    bit    hit;
    bit    bad;
    byte_t count;
    hit = 1'b0;
    r   = '0;
    if (!p_in_frame) begin
      if (b == DELIM) clear_decoder(1'b1);
    end else if (b == DELIM) begin
      bad = !p_want_code;
      if (p_hold_valid) r = '{p_hold_byte, 1'b1, 1'b0, bad};
      else r = '{8'h00, 1'b1, 1'b1, bad};
      clear_decoder(1'b0);
      hit = 1'b1;
    end else if (p_want_code) begin
      count = b - 8'd1;
      if (p_zero_due) hit = pass_through_hold(FILL_ZERO, r);
      p_full_block = (count >= CODE_FULL_COUNT);
      p_bytes_left = count;
      if (count == 8'd0) begin
        p_want_code = 1'b1;
        p_zero_due  = !p_full_block;
      end else begin
        p_want_code = 1'b0;
        p_zero_due  = 1'b0;
      end
    end else begin
      hit = pass_through_hold(b, r);
      p_bytes_left = p_bytes_left - 8'd1;
      if (p_bytes_left == 8'd0) begin
        p_want_code = 1'b1;
        p_zero_due  = !p_full_block;
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one link item, idling at random first; return once it is accepted
  task automatic send_link(input byte_t b);
    while ($urandom_range(0, 99) < send_idle) begin
      link.valid <= 1'b0;
      @(posedge clk);
    end
    link.valid     <= 1'b1;
    link.link_byte <= b;
    @(posedge clk);
    while (link.ready !== 1'b1) @(posedge clk);
  endtask

  // Append one frame, possibly broken or preceded by noise, to the link plan
  task automatic plan_frame(input bit long_frame);
    byte_t payload[$];
    byte_t blk[$];
    byte_t enc[$];
    int    len;
    int    zero_pct;
    int    roll;
    int    keep;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 4)) link_plan = {link_plan, byte_t'($urandom_range(1, 255))};
    end
    len      = long_frame ? $urandom_range(254, 300) : $urandom_range(0, 12);
    zero_pct = long_frame ? 0 : 30;
    repeat (len) begin
      if ($urandom_range(0, 99) < zero_pct) payload = {payload, 8'h00};
      else payload = {payload, byte_t'($urandom_range(long_frame ? 1 : 0, 255))};
    end
    // COBS-encode: flush a block on each zero or after 254 nonzero bytes
    foreach (payload[i]) begin
      if (payload[i] == 8'h00) begin
        enc = {enc, byte_t'(blk.size() + 1)};
        enc = {enc, blk};
        blk.delete();
      end else begin
        blk = {blk, payload[i]};
        if (blk.size() == 254) begin
          enc = {enc, 8'hFF};
          enc = {enc, blk};
          blk.delete();
        end
      end
    end
    enc = {enc, byte_t'(blk.size() + 1)};
    enc = {enc, blk};
    // Break some frames: truncate, or replace the body with garbage
    if (roll >= 10 && roll < 25) begin
      keep = $urandom_range(0, enc.size());
      while (enc.size() > keep) enc.delete(enc.size() - 1);
    end else if (roll >= 25 && roll < 32) begin
      enc.delete();
      repeat ($urandom_range(1, 8)) enc = {enc, byte_t'($urandom_range(1, 255))};
    end
    link_plan = {link_plan, DELIM};
    link_plan = {link_plan, enc};
    link_plan = {link_plan, DELIM};
  endtask

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall at random
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst === 1'b0 && result.valid === 1'b1 && result.ready === 1'b1) begin
      got = '{result.data_byte, result.frame_last, result.frame_empty, result.frame_bad};
      if (decoded_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item data=%02h last=%0b empty=%0b bad=%0b",
                                  got.data_byte, got.frame_last, got.frame_empty,
                                  got.frame_bad));
      end else begin
        want = decoded_due.pop_front();
        if (got.data_byte !== want.data_byte || got.frame_last !== want.frame_last ||
            got.frame_empty !== want.frame_empty || got.frame_bad !== want.frame_bad) begin
          report_mismatch($sformatf(
            "got data=%02h last=%0b empty=%0b bad=%0b, want data=%02h last=%0b empty=%0b bad=%0b",
            got.data_byte, got.frame_last, got.frame_empty, got.frame_bad,
            want.data_byte, want.frame_last, want.frame_empty, want.frame_bad));
        end
      end
    end
  end

  // Stimulus
  initial begin
    result_t r;
    bit      hit;
    int      frames;
    mismatches = 0;
    send_idle  = send_pct[0];
    recv_idle  = recv_pct[0];
    clear_decoder(1'b0);
    rst            <= 1'b1;
    link.valid     <= 1'b0;
    link.link_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (dir_rows[i]) begin
      send_link(dir_rows[i].b);
      hit = cobs_predict(dir_rows[i].b, r);
      case (dir_rows[i].kind)
        ROW_TYPED: decoded_due = {decoded_due, dir_rows[i].want};
        ROW_MODEL: if (hit) decoded_due = {decoded_due, r};
        default: ;
      endcase
    end

    // Random frames under each idling setting
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = send_pct[ph];
      recv_idle = recv_pct[ph];
      link_plan.delete();
      frames = 0;
      while (link_plan.size() < PHASE_ITEMS) begin
        plan_frame(ph == 2 && frames == 3);
        frames++;
      end
      foreach (link_plan[i]) begin
        send_link(link_plan[i]);
        if (cobs_predict(link_plan[i], r)) decoded_due = {decoded_due, r};
      end
    end
    link.valid <= 1'b0;

    // Drain
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (result.valid === 1'b1) report_mismatch("result valid with nothing expected");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
